### design/hcp_pkg.sv
package hcp_pkg;

	localparam int EDGE_W = 18;
	localparam int DIV_W = 20;
	localparam int SW = DIV_W + 2;
	localparam int HEX_W = 16;

	localparam logic [EDGE_W-1:0] EDGE_RESET = 18'd25600;
	localparam logic [16:0] SQRT3_Q16 = 17'd113512;
	localparam logic [35:0] ROUND_HALF = 36'd32768;

	typedef enum logic [1:0] {
		ANCHOR_0,
		ANCHOR_1,
		ANCHOR_2
	} anchor_t;

endpackage

### design/hcp_pt_if.sv
interface hcp_pt_if #(
	parameter int COORD_BITS = 24
) ();
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] x_pos;
	logic signed [COORD_BITS-1:0] y_pos;

	modport source (output valid, output x_pos, output y_pos, input ready);
	modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

### design/hcp_res_if.sv
interface hcp_res_if ();
	logic valid;
	logic ready;
	logic signed [hcp_pkg::HEX_W-1:0] hex_q;
	logic signed [hcp_pkg::HEX_W-1:0] hex_r;
	logic [1:0] anchor_chosen;
	logic early_capture;
	logic saturated;

	modport source (output valid, output hex_q, output hex_r, output anchor_chosen,
		output early_capture, output saturated, input ready);
	modport sink (input valid, input hex_q, input hex_r, input anchor_chosen,
		input early_capture, input saturated, output ready);
endinterface

### design/hex_cell_pick_from_point.sv
// pipeline: a request passes one input stage, one divider stage per coordinate bit and
//   five stages of distance and selection before its result is presented
// throughput: one request per cycle; the whole pipeline holds while a result waits
// reset: arst_n clears all valid bits and sets edge_length to 25600
module hex_cell_pick_from_point #(
	parameter int COORD_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [hcp_pkg::EDGE_W-1:0] cfg_wdata,
	hcp_pt_if.sink pt,
	hcp_res_if.source res
);
	localparam int C = COORD_BITS;
	localparam int DW = hcp_pkg::DIV_W;

	logic [hcp_pkg::EDGE_W-1:0] edge_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= hcp_pkg::EDGE_RESET;
		end else if (cfg_we) begin
			edge_q <= cfg_wdata;
		end
	end

	assign en = !(res.valid && !res.ready);
	assign pt.ready = en;

	// unit widths from the edge length, zero edge treated as one lsb
	logic [hcp_pkg::EDGE_W-1:0] edge_eff;
	logic [35:0] prod;
	logic [DW-1:0] ux;
	logic [C:0] px2, py2;

	always_comb begin
		edge_eff = (edge_q == '0) ? hcp_pkg::EDGE_W'(1) : edge_q;
		prod = 36'(edge_eff) * 36'(hcp_pkg::SQRT3_Q16) + hcp_pkg::ROUND_HALF;
		ux = {1'b0, prod[34:16]};
		px2 = {pt.x_pos, 1'b0};
		py2 = {pt.y_pos, 1'b0};
	end

	logic v_s1;
	logic [C-1:0] nx_s1, ny_s1;
	logic negx_s1, negy_s1;
	logic [DW-1:0] bx_s1, uy2_s1;

	// negative dividends go through as -a-1 so floor needs no remainder fixup
	always_ff @(posedge clk) begin
		if (en) begin
			negx_s1 <= px2[C];
			negy_s1 <= py2[C];
			nx_s1 <= px2[C] ? ~px2[C-1:0] : px2[C-1:0];
			ny_s1 <= py2[C] ? ~py2[C-1:0] : py2[C-1:0];
			bx_s1 <= {ux[DW-2:0], 1'b0};
			uy2_s1 <= DW'(edge_eff) + DW'({edge_eff, 1'b0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pt.valid;
		end
	end

	logic vx, vy, negx, negy;
	logic [C-1:0] q0x, q0y;
	logic [DW-1:0] remx, remy, bx, uy2;

	hcp_divider #(.C(C)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_n(nx_s1), .in_neg(negx_s1), .in_d(bx_s1),
		.out_valid(vx), .out_q(q0x), .out_rem(remx), .out_d(bx), .out_neg(negx)
	);

	hcp_divider #(.C(C)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_n(ny_s1), .in_neg(negy_s1), .in_d(uy2_s1),
		.out_valid(vy), .out_q(q0y), .out_rem(remy), .out_d(uy2), .out_neg(negy)
	);

	hcp_pkg::anchor_t anchor;

	hcp_pick #(.C(C)) u_pick (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vx),
		.q0x(q0x), .remx(remx), .bx(bx), .negx(negx),
		.q0y(q0y), .remy(remy), .uy2(uy2), .negy(negy),
		.out_valid(res.valid), .hex_q(res.hex_q), .hex_r(res.hex_r),
		.anchor_chosen(anchor), .early_capture(res.early_capture),
		.saturated(res.saturated)
	);

	assign res.anchor_chosen = anchor;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n) vx == vy)
		else $error("x and y dividers out of step");

	a_anchor_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.anchor_chosen != 2'd3)
		else $error("anchor out of range");

	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.hex_q != 16'sh7fff && res.hex_q != 16'sh8000
		&& res.hex_r != 16'sh7fff && res.hex_r != 16'sh8000 |-> !res.saturated)
		else $error("saturated set without a clamped coordinate");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.hex_q) && $stable(res.hex_r))
		else $error("result changed while stalled");
endmodule

### design/hcp_divider.sv
// restoring divider, one quotient bit per stage, msb first
module hcp_divider #(
	parameter int C = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [C-1:0] in_n,
	input  logic in_neg,
	input  logic [hcp_pkg::DIV_W-1:0] in_d,
	output logic out_valid,
	output logic [C-1:0] out_q,
	output logic [hcp_pkg::DIV_W-1:0] out_rem,
	output logic [hcp_pkg::DIV_W-1:0] out_d,
	output logic out_neg
);
	localparam int DW = hcp_pkg::DIV_W;

	logic v_s [C+1];
	logic [C-1:0] n_s [C+1];
	logic [C-1:0] q_s [C+1];
	logic [DW-1:0] rem_s [C+1];
	logic [DW-1:0] d_s [C+1];
	logic neg_s [C+1];

	assign v_s[0] = in_valid;
	assign n_s[0] = in_n;
	assign q_s[0] = '0;
	assign rem_s[0] = '0;
	assign d_s[0] = in_d;
	assign neg_s[0] = in_neg;

	for (genvar i = 0; i < C; i++) begin : g_stage
		logic [DW:0] trial;
		logic ge;
		logic [DW:0] diff;

		always_comb begin
			trial = {rem_s[i], n_s[i][C-1]};
			ge = (trial >= {1'b0, d_s[i]});
			diff = trial - {1'b0, d_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1] <= {n_s[i][C-2:0], 1'b0};
				q_s[i+1] <= {q_s[i][C-2:0], ge};
				rem_s[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				d_s[i+1] <= d_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign out_valid = v_s[C];
	assign out_q = q_s[C];
	assign out_rem = rem_s[C];
	assign out_d = d_s[C];
	assign out_neg = neg_s[C];
endmodule

### design/hcp_pick.sv
module hcp_pick #(
	parameter int C = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [C-1:0] q0x,
	input  logic [hcp_pkg::DIV_W-1:0] remx,
	input  logic [hcp_pkg::DIV_W-1:0] bx,
	input  logic negx,
	input  logic [C-1:0] q0y,
	input  logic [hcp_pkg::DIV_W-1:0] remy,
	input  logic [hcp_pkg::DIV_W-1:0] uy2,
	input  logic negy,
	output logic out_valid,
	output logic signed [hcp_pkg::HEX_W-1:0] hex_q,
	output logic signed [hcp_pkg::HEX_W-1:0] hex_r,
	output hcp_pkg::anchor_t anchor_chosen,
	output logic early_capture,
	output logic saturated
);
	localparam int DW = hcp_pkg::DIV_W;
	localparam int SW = hcp_pkg::SW;
	localparam int HW = hcp_pkg::HEX_W;
	localparam int KW = C + 3;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1: true floor indices and offsets inside the rectangle
	logic signed [C:0] ix_s1, iy_s1;
	logic [DW-1:0] dx0_s1, dyb_s1, ux_s1, uy2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s1 <= negx ? ~{1'b0, q0x} : {1'b0, q0x};
			iy_s1 <= negy ? ~{1'b0, q0y} : {1'b0, q0y};
			dx0_s1 <= negx ? (bx - remx - DW'(1)) : remx;
			dyb_s1 <= negy ? (uy2 - remy - DW'(1)) : remy;
			ux_s1 <= {1'b0, bx[DW-1:1]};
			uy2_s1 <= uy2;
		end
	end

	// stage 2: offsets to each candidate centre
	logic signed [C:0] ix_s2, iy_s2;
	logic signed [SW-1:0] dx_s2 [3];
	logic signed [SW-1:0] dy02_s2, dy1_s2;
	logic [DW-1:0] ux_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s2 <= ix_s1;
			iy_s2 <= iy_s1;
			ux_s2 <= ux_s1;
			dx_s2[0] <= $signed({2'b00, dx0_s1});
			dx_s2[1] <= $signed({2'b00, dx0_s1}) - $signed({2'b00, ux_s1});
			dx_s2[2] <= $signed({2'b00, dx0_s1}) - $signed({1'b0, ux_s1, 1'b0});
			// odd rows put centres 0 and 2 on the next row up
			if (iy_s1[0]) begin
				dy02_s2 <= $signed({2'b00, dyb_s1}) - $signed({2'b00, uy2_s1});
				dy1_s2 <= $signed({2'b00, dyb_s1});
			end else begin
				dy02_s2 <= $signed({2'b00, dyb_s1});
				dy1_s2 <= $signed({2'b00, dyb_s1}) - $signed({2'b00, uy2_s1});
			end
		end
	end

	// stage 3: squares
	logic signed [C:0] ix_s3, iy_s3;
	logic [2*SW-1:0] sx_s3 [3];
	logic [2*SW-1:0] sy02_s3, sy1_s3, lim_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s3 <= ix_s2;
			iy_s3 <= iy_s2;
			for (int j = 0; j < 3; j++) begin
				sx_s3[j] <= (2*SW)'(dx_s2[j] * dx_s2[j]);
			end
			sy02_s3 <= (2*SW)'(dy02_s2 * dy02_s2);
			sy1_s3 <= (2*SW)'(dy1_s2 * dy1_s2);
			lim_s3 <= (2*SW)'({2'b00, ux_s2} * {2'b00, ux_s2});
		end
	end

	// stage 4: squared distances
	logic signed [C:0] ix_s4, iy_s4;
	logic [2*SW-1:0] d2_s4 [3];
	logic [2*SW-1:0] lim_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s4 <= ix_s3;
			iy_s4 <= iy_s3;
			lim_s4 <= lim_s3;
			d2_s4[0] <= sx_s3[0] + sy02_s3;
			d2_s4[1] <= sx_s3[1] + sy1_s3;
			d2_s4[2] <= sx_s3[2] + sy02_s3;
		end
	end

	// stage 5: selection and axial coordinates
	hcp_pkg::anchor_t pick;
	logic early;
	logic [2*SW-1:0] best;
	logic signed [KW-1:0] ix_w, iy_w, kx, ky, diff;
	logic signed [C+1:0] qv, rv;
	logic signed [HW-1:0] qc, rc;
	logic sat;

	always_comb begin
		best = d2_s4[0];
		pick = hcp_pkg::ANCHOR_0;
		early = 1'b0;
		priority if (d2_s4[0] < lim_s4) begin
			early = 1'b1;
		end else if (d2_s4[1] < lim_s4) begin
			pick = hcp_pkg::ANCHOR_1;
			early = 1'b1;
		end else if (d2_s4[2] < lim_s4) begin
			pick = hcp_pkg::ANCHOR_2;
			early = 1'b1;
		end else begin
			// strict compare keeps ties on the earlier centre
			if (d2_s4[1] < best) begin
				best = d2_s4[1];
				pick = hcp_pkg::ANCHOR_1;
			end
			if (d2_s4[2] < best) begin
				pick = hcp_pkg::ANCHOR_2;
			end
		end

		ix_w = {{2{ix_s4[C]}}, ix_s4};
		iy_w = {{2{iy_s4[C]}}, iy_s4};
		unique case (pick)
			hcp_pkg::ANCHOR_1: begin
				kx = (ix_w <<< 1) + KW'(1);
				ky = iy_s4[0] ? iy_w : iy_w + KW'(1);
			end
			hcp_pkg::ANCHOR_2: begin
				kx = (ix_w <<< 1) + KW'(2);
				ky = iy_s4[0] ? iy_w + KW'(1) : iy_w;
			end
			default: begin
				kx = ix_w <<< 1;
				ky = iy_s4[0] ? iy_w + KW'(1) : iy_w;
			end
		endcase
		// kx - ky is always even
		diff = kx - ky;
		qv = diff[KW-1:1];
		rv = ky[C+1:0];

		sat = 1'b0;
		if (qv > $signed((C+2)'(32767))) begin
			qc = 16'sh7fff;
			sat = 1'b1;
		end else if (qv < -$signed((C+2)'(32768))) begin
			qc = -16'sh8000;
			sat = 1'b1;
		end else begin
			qc = qv[HW-1:0];
		end
		if (rv > $signed((C+2)'(32767))) begin
			rc = 16'sh7fff;
			sat = 1'b1;
		end else if (rv < -$signed((C+2)'(32768))) begin
			rc = -16'sh8000;
			sat = 1'b1;
		end else begin
			rc = rv[HW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hex_q <= qc;
			hex_r <= rc;
			anchor_chosen <= pick;
			early_capture <= early;
			saturated <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign out_valid = v_s5;
endmodule

### tb/hex_cell_pick_from_point_tb.sv
module hex_cell_pick_from_point_tb;

	typedef struct {
		logic signed [hcp_pkg::HEX_W-1:0] q;
		logic signed [hcp_pkg::HEX_W-1:0] r;
		hcp_pkg::anchor_t anchor;
		bit early;
		bit sat;
	} hex_pick_t;

	class hex_pick_board;
		hex_pick_t picks_due[$];
		logic [hcp_pkg::EDGE_W-1:0] edge_len;
		int errors;

		function new();
			edge_len = hcp_pkg::EDGE_RESET;
			errors = 0;
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		function longint unit_x();
			longint e;
			e = (edge_len == 0) ? 1 : longint'(edge_len);
			return (e * 113512 + 32768) >>> 16;
		endfunction

		function longint floor_div(longint a, longint b);
			longint d;
			d = a / b;
			if ((a % b) != 0 && a < 0) d = d - 1;
			return d;
		endfunction

		function hex_pick_t pick_cell(logic signed [23:0] x, logic signed [23:0] y);
			hex_pick_t p;
			longint e, ux, uy2, px2, py2, ix, iy, lim2, best, dx, dy, d2, q, r;
			longint kx[3];
			longint ky[3];
			int pick;
			bit early, sat;
			e = (edge_len == 0) ? 1 : longint'(edge_len);
			ux = unit_x();
			uy2 = 3 * e;
			px2 = 2 * longint'(x);
			py2 = 2 * longint'(y);
			ix = floor_div(px2, 2 * ux);
			iy = floor_div(py2, uy2);
			for (int i = 0; i < 3; i++) kx[i] = 2 * ix + i;
			// row parity decides whether the middle centre sits above or below
			if (iy[0] == 1'b0) begin
				ky[0] = iy; ky[2] = iy; ky[1] = iy + 1;
			end else begin
				ky[0] = iy + 1; ky[2] = iy + 1; ky[1] = iy;
			end
			lim2 = ux * ux;
			best = 64'd5120000 * 64'd5120000;
			pick = 0;
			early = 0;
			sat = 0;
			for (int i = 0; i < 3; i++) begin
				dx = px2 - kx[i] * ux;
				dy = py2 - ky[i] * uy2;
				d2 = dx * dx + dy * dy;
				if (!early) begin
					if (d2 < lim2) begin
						pick = i;
						early = 1;
					end else if (d2 < best) begin
						best = d2;
						pick = i;
					end
				end
			end
			q = (kx[pick] - ky[pick]) / 2;
			r = ky[pick];
			if (q > 32767) begin q = 32767; sat = 1; end
			if (q < -32768) begin q = -32768; sat = 1; end
			if (r > 32767) begin r = 32767; sat = 1; end
			if (r < -32768) begin r = -32768; sat = 1; end
			p.q = q[15:0];
			p.r = r[15:0];
			p.anchor = hcp_pkg::anchor_t'(pick);
			p.early = early;
			p.sat = sat;
			return p;
		endfunction

		function void note_request(logic signed [23:0] x, logic signed [23:0] y);
			picks_due.push_back(pick_cell(x, y));
		endfunction

		task check_result(logic signed [hcp_pkg::HEX_W-1:0] q,
			logic signed [hcp_pkg::HEX_W-1:0] r, logic [1:0] a, logic e, logic s);
			hex_pick_t p;
			if (picks_due.size() == 0) begin
				report("result with nothing expected");
				return;
			end
			p = picks_due.pop_front();
			if (q !== p.q) report($sformatf("hex_q got %0d want %0d", q, p.q));
			if (r !== p.r) report($sformatf("hex_r got %0d want %0d", r, p.r));
			if (a !== p.anchor) report($sformatf("anchor got %0d want %0d", a, p.anchor));
			if (e !== p.early) report($sformatf("early_capture got %b want %b", e, p.early));
			if (s !== p.sat) report($sformatf("saturated got %b want %b", s, p.sat));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [hcp_pkg::EDGE_W-1:0] cfg_wdata = '0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_req = 0;
	int hold_left = 0;
	hex_pick_board sb;

	hcp_pt_if #(.COORD_BITS(24)) pt ();
	hcp_res_if res ();

	hex_cell_pick_from_point #(.COORD_BITS(24)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.pt(pt), .res(res)
	);

	always #5 clk = ~clk;

	initial begin
		pt.valid = 0;
		pt.x_pos = '0;
		pt.y_pos = '0;
		res.ready = 0;
	end

	always @(posedge clk) begin
		if (res.valid && res.ready)
			sb.check_result(res.hex_q, res.hex_r, res.anchor_chosen, res.early_capture,
				res.saturated);
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 0;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_request(logic signed [23:0] x, logic signed [23:0] y);
		pt.valid <= 1;
		pt.x_pos <= x;
		pt.y_pos <= y;
		do @(posedge clk); while (!pt.ready);
		sb.note_request(x, y);
		if ($urandom_range(99) < send_idle) begin
			pt.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (pt.valid) begin
			pt.valid <= 0;
			@(posedge clk);
		end
		while (sb.picks_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_edge(logic [hcp_pkg::EDGE_W-1:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.edge_len = v;
	endtask

	task automatic send_random();
		longint ux, cx, cy;
		logic signed [23:0] x, y;
		ux = sb.unit_x();
		if ($urandom_range(2) == 0) begin
			x = 24'($urandom);
			y = 24'($urandom);
		end else begin
			// near a candidate centre, around the inner radius and cell borders
			cx = ($signed($urandom_range(40)) - 20) * ux;
			cy = ($signed($urandom_range(40)) - 20) * 3 * longint'(sb.edge_len) / 2;
			x = 24'(cx + $signed($urandom_range(32'(2 * ux + 2))) - ux - 1);
			y = 24'(cy + $signed($urandom_range(32'(2 * ux + 2))) - ux - 1);
		end
		send_request(x, y);
	endtask

	initial begin
		logic [hcp_pkg::EDGE_W-1:0] edges [6];
		longint ux;
		longint el;
		sb = new();
		edges = '{hcp_pkg::EDGE_RESET, 18'd1, 18'd0, 18'h3FFFF, 18'd256, 18'd0};
		edges[5] = 18'($urandom_range(2, 262142));
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int p = 0; p < 6; p++) begin
			send_idle = (p < 2) ? 11 : (p < 4) ? 75 : 0;
			recv_idle = (p < 2) ? 75 : (p < 4) ? 11 : 0;
			if (p != 0) write_edge(edges[p]);
			ux = sb.unit_x();
			el = longint'(sb.edge_len);
			send_request('0, '0);
			send_request(24'sh7FFFFF, 24'sh7FFFFF);
			send_request(-24'sh800000, -24'sh800000);
			send_request(24'sh7FFFFF, -24'sh800000);
			send_request(-24'sh800000, 24'sh7FFFFF);
			send_request(24'(-ux), '0);
			send_request(24'(-2 * ux), 24'(-3 * el));
			send_request('0, 24'(-3 * el / 2));
			send_request(24'(ux / 2), 24'(3 * el / 2));
			send_request(24'(ux / 2 + 1), '0);
			send_request(-24'sd1, -24'sd1);
			send_request(24'(ux), 24'(3 * el));
			for (int i = 0; i < 76; i++) begin
				if (p == 1 && i == 20) hold_req = 400;
				if (p == 2 && i == 30) begin
					pt.valid <= 0;
					@(posedge clk);
					while (sb.picks_due.size() != 0) @(posedge clk);
				end
				send_random();
			end
			drain();
		end
		if (sb.picks_due.size() != 0) sb.report("results still expected at end");
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
